[design/lifo_stack_with_search_unit_assert.svh]
// Assertion macros for the LIFO stack with search unit.
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checks a property on the rising clock edge while reset is released.
`define LSWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lifo stack assertion failed");
// Checks that a condition never holds.
`define LSWS_ASSERT_NEVER(lbl, cond) \
  `LSWS_ASSERT(lbl, !(cond))
`else
`define LSWS_ASSERT(lbl, prop)
`define LSWS_ASSERT_NEVER(lbl, cond)
`endif

`endif

[design/lsws_pkg.sv]
// Package with sizes, codes and interface types of the LIFO stack with search.
package lsws_pkg;

  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 9;
  localparam int CAP_RESET = 256;
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 32;
  localparam int MIDX_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    logic    clear;
    logic    scan_start;
    logic    scan_next;
    logic    emit;
    status_e st;
    logic    data_en;
    logic    midx_en;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              empty;
    logic              full;
    logic              hit;
    logic              ptr_zero;
  } dp_stat_t;

endpackage

[design/lsws_ctrl.sv]
// Controller state machine of the LIFO stack with search.
module lsws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lsws_pkg::dp_stat_t stat_i,
  output lsws_pkg::dp_cmd_t  cmd_o
);
  import lsws_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.op == OP_SEARCH && !stat_i.empty) state_d = S_SCAN;
        else state_d = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.ptr_zero) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.st = ST_OK;
    busy = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_PUSH: begin
            cmd_o.emit = 1'b1;
            if (stat_i.full) cmd_o.st = ST_FULL;
            else cmd_o.push = 1'b1;
          end
          OP_POP: begin
            cmd_o.emit = 1'b1;
            if (stat_i.empty) begin
              cmd_o.st = ST_EMPTY;
            end else begin
              cmd_o.pop     = 1'b1;
              cmd_o.data_en = 1'b1;
            end
          end
          OP_PEEK: begin
            cmd_o.emit = 1'b1;
            if (stat_i.empty) cmd_o.st = ST_EMPTY;
            else cmd_o.data_en = 1'b1;
          end
          OP_CLEAR: begin
            cmd_o.emit  = 1'b1;
            cmd_o.clear = 1'b1;
          end
          OP_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.st   = ST_NOTFOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
            end
          end
          default: cmd_o.emit = 1'b1;
        endcase
      end
      S_SCAN: begin
        // The read data always belongs to the entry the pointer names.
        priority if (stat_i.hit) begin
          cmd_o.emit    = 1'b1;
          cmd_o.midx_en = 1'b1;
        end else if (stat_i.ptr_zero) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = ST_NOTFOUND;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/lsws_dp.sv]
// Datapath of the LIFO stack with search: storage, count, scan pointer, result registers.
module lsws_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lsws_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [lsws_pkg::DATA_W-1:0]  value_i,
  input  logic                                cfg_we_i,
  input  logic [lsws_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  lsws_pkg::dp_cmd_t                   cmd_i,
  output lsws_pkg::dp_stat_t                  stat_o,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [lsws_pkg::DATA_W-1:0]  data_o,
  output logic [lsws_pkg::MIDX_W-1:0]         match_index_o,
  output logic [lsws_pkg::COUNT_W-1:0]        count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import lsws_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [FUNC_W-1:0] func_q;
  logic [DATA_W-1:0] value_q;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [DATA_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  count_dec;
  logic [ADDR_W-1:0] ptr_dec;
  logic [CMP_W-1:0]  cap_ext, eff_cap;
  logic              done_q;
  status_e           status_q;
  logic [DATA_W-1:0] data_q;
  logic [MIDX_W-1:0] midx_q;
  logic [CNT_W-1:0]  count_out_q;
  logic              empty_out_q, full_out_q;

  assign count_dec = count_q - 1'b1;
  assign ptr_dec   = ptr_q - 1'b1;
  assign cap_ext   = CMP_W'(cap_q);
  assign eff_cap   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

  // Outside a scan the top entry is read, so pop and peek find it ready.
  assign rd_addr = cmd_i.scan_next ? ptr_dec : count_dec[ADDR_W-1:0];

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.clear) count_d = '0;
    else if (cmd_i.push) count_d = count_q + 1'b1;
    else if (cmd_i.pop) count_d = count_dec;
    else count_d = count_q;
  end

  always_comb begin
    ptr_d = ptr_q;
    priority if (cmd_i.scan_start) ptr_d = count_dec[ADDR_W-1:0];
    else if (cmd_i.scan_next) ptr_d = ptr_dec;
    else ptr_d = ptr_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[count_q[ADDR_W-1:0]] <= value_q;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
    ptr_q <= ptr_d;
    if (cmd_i.emit) begin
      status_q <= cmd_i.st;
      data_q   <= cmd_i.data_en ? rd_data_q : '0;
      midx_q   <= cmd_i.midx_en ? MIDX_W'(ptr_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_W'(CAP_RESET);
      count_q     <= '0;
      done_q      <= 1'b0;
      count_out_q <= '0;
      empty_out_q <= 1'b1;
      full_out_q  <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      count_q <= count_d;
      done_q  <= cmd_i.emit;
      if (cmd_i.emit) begin
        count_out_q <= count_d;
        empty_out_q <= (count_d == '0);
        full_out_q  <= (CMP_W'(count_d) >= eff_cap);
      end
    end
  end

  assign stat_o.op       = func_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (CMP_W'(count_q) >= eff_cap);
  assign stat_o.hit      = (rd_data_q == value_q);
  assign stat_o.ptr_zero = (ptr_q == '0);

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign data_o        = data_q;
  assign match_index_o = midx_q;
  assign count_o       = COUNT_W'(count_out_q);
  assign is_empty_o    = empty_out_q;
  assign is_full_o     = full_out_q;

endmodule

[design/lifo_stack_with_search_unit.sv]
// Top level of the LIFO stack with search: controller, datapath and checks.
//
// An item (func_i, value_i) is taken at a rising edge with start high and busy low.
// busy rises for the cycles the item is at work; each item gives one result,
// shown for exactly one cycle with done_o high, together with status_o, data_o,
// match_index_o, count_o, is_empty_o and is_full_o. The receiver cannot stall.
// Push, pop, peek, clear and unused codes: the result is registered from the EXEC
// state, and busy is low again during that result cycle, so a new item can be
// taken then. Search walks the stored entries from the top, one entry per cycle
// through the registered read port of the stack memory, and stops at the first
// match or after the bottom entry; an empty stack gives its result from EXEC.
// The capacity register is written with cfg_we_i and cfg_wdata_i; the user must
// write it only while idle (the block does not enforce this). Values above the
// stack depth act as the depth.
// Reset empties the stack and sets the capacity to 256; the memory is not
// cleared, since an entry is only read after a push has written it.
module lifo_stack_with_search_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [lsws_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [lsws_pkg::DATA_W-1:0]  value_i,
  input  logic                                cfg_we_i,
  input  logic [lsws_pkg::CAP_W-1:0]          cfg_wdata_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [lsws_pkg::DATA_W-1:0]  data_o,
  output logic [lsws_pkg::MIDX_W-1:0]         match_index_o,
  output logic [lsws_pkg::COUNT_W-1:0]        count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import lsws_pkg::*;

  `include "lifo_stack_with_search_unit_assert.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lsws_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lsws_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .data_o        (data_o),
    .match_index_o (match_index_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // A result cycle always finds the controller idle again.
  `LSWS_ASSERT_NEVER(a_done_while_busy, done_o && busy)
  // Items other than search deliver their result straight from the EXEC state.
  `LSWS_ASSERT(a_fixed_latency, (start && !busy && func_i != OP_SEARCH) |-> ##2 done_o)
  // A rejected push leaves the stack full.
  `LSWS_ASSERT(a_full_flag, (done_o && status_o == ST_FULL) |-> is_full_o)
  // An empty pop or peek returns zero on an empty stack.
  `LSWS_ASSERT(a_empty_result, (done_o && status_o == ST_EMPTY) |-> (is_empty_o && data_o == '0))

endmodule
